[hw/rtl/ltng_pkg.sv]
// Shared types, constants and helper functions for the lagged-table noise generator.
package ltng_pkg;

  localparam int TBL_LEN    = 17;
  localparam int IDX_W      = 5;
  localparam int WORD_W     = 32;
  localparam int AMP_W      = 24;
  localparam int NOISE_W    = 25;
  localparam int DIFF_W     = WORD_W + 1;
  localparam int NPROD_W    = AMP_W + DIFF_W;
  localparam int FRAC_SHIFT = 31;
  localparam int UPC_W      = 4;

  localparam int MIX_ROUNDS = 8;
  localparam int ROUND_W    = (MIX_ROUNDS < 2) ? 1 : $clog2(MIX_ROUNDS);
  localparam logic [ROUND_W-1:0] LAST_ROUND =
    ROUND_W'((MIX_ROUNDS > 0) ? (MIX_ROUNDS - 1) : 0);

  localparam logic [WORD_W-1:0] RESET_WORDS [TBL_LEN] = '{
    32'h3847a384, 32'h56af9029, 32'hc3852109, 32'h01835567,
    32'h58927374, 32'h77733935, 32'habcdef09, 32'h19258761,
    32'h58585716, 32'hd08f0ea0, 32'h44a5face, 32'hc0feeba6,
    32'h67860a38, 32'h45871265, 32'h9fbc0e38, 32'h35175722,
    32'h45787162
  };

  localparam logic signed [DIFF_W-1:0] DIFF_BIAS = 33'sh0_8000_0000;

  typedef enum logic [3:0] {
    ACT_LOAD     = 4'd0,
    ACT_TMP      = 4'd1,
    ACT_XOR_ADD  = 4'd2,
    ACT_ROT_ADD  = 4'd3,
    ACT_MUL      = 4'd4,
    ACT_PROD_ADD = 4'd5,
    ACT_SEED_XOR = 4'd6,
    ACT_SEED_MUL = 4'd7,
    ACT_SEED_ADD = 4'd8,
    ACT_WRITE    = 4'd9,
    ACT_DIFF     = 4'd10,
    ACT_NOISE    = 4'd11
  } act_t;

  typedef enum logic [2:0] {
    PROG_SEED = 3'b001,
    PROG_MIX  = 3'b010,
    PROG_REQ  = 3'b100
  } prog_t;

  typedef struct packed {
    logic             rd;
    logic [IDX_W-1:0] off;
    act_t             act;
    logic             last;
  } uop_t;

  typedef struct packed {
    logic [WORD_W-1:0]        acc;
    logic [WORD_W-1:0]        tmp;
    logic [WORD_W-1:0]        prod;
    logic signed [DIFF_W-1:0] diff;
    logic signed [NPROD_W-1:0] nprod;
  } dp_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [IDX_W-1:0]  addr;
    logic [WORD_W-1:0] wr_data;
  } tbl_req_t;

  typedef struct packed {
    logic                      valid;
    logic signed [NOISE_W-1:0] noise;
    logic [WORD_W-1:0]         raw_word;
  } res_t;

  function automatic logic [WORD_W-1:0] rotl3(input logic [WORD_W-1:0] v);
    return {v[WORD_W-4:0], v[WORD_W-1:WORD_W-3]};
  endfunction

  function automatic logic [IDX_W-1:0] addr_wrap(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] off);
    logic [IDX_W:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (IDX_W+1)'(TBL_LEN)) begin
      s = s - (IDX_W+1)'(TBL_LEN);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic uop_t mk(input logic rd, input int off, input act_t act,
                              input logic last);
    uop_t u;
    u.rd   = rd;
    u.off  = IDX_W'(off);
    u.act  = act;
    u.last = last;
    return u;
  endfunction

  // Microprogram: the mix and request passes update one word each; the seed pass updates two
  function automatic uop_t uop(input prog_t prog, input logic [UPC_W-1:0] upc);
    uop_t u;
    u = mk(1'b0, 0, ACT_WRITE, 1'b1);
    case (prog)
      PROG_SEED: begin
        case (upc)
          4'd0: u = mk(1'b1, 0, ACT_SEED_XOR, 1'b0);
          4'd1: u = mk(1'b0, 0, ACT_WRITE,    1'b0);
          4'd2: u = mk(1'b0, 0, ACT_SEED_MUL, 1'b0);
          4'd3: u = mk(1'b1, 1, ACT_SEED_ADD, 1'b0);
          4'd4: u = mk(1'b0, 1, ACT_WRITE,    1'b1);
          default: u = mk(1'b0, 1, ACT_WRITE, 1'b1);
        endcase
      end
      PROG_MIX: begin
        case (upc)
          4'd0: u = mk(1'b1, 0,  ACT_LOAD,    1'b0);
          4'd1: u = mk(1'b1, 7,  ACT_TMP,     1'b0);
          4'd2: u = mk(1'b1, 5,  ACT_XOR_ADD, 1'b0);
          4'd3: u = mk(1'b1, 13, ACT_ROT_ADD, 1'b0);
          4'd4: u = mk(1'b0, 0,  ACT_WRITE,   1'b1);
          default: u = mk(1'b0, 0, ACT_WRITE, 1'b1);
        endcase
      end
      PROG_REQ: begin
        case (upc)
          4'd0: u = mk(1'b1, 0,  ACT_LOAD,     1'b0);
          4'd1: u = mk(1'b1, 4,  ACT_TMP,      1'b0);
          4'd2: u = mk(1'b1, 13, ACT_XOR_ADD,  1'b0);
          4'd3: u = mk(1'b1, 10, ACT_ROT_ADD,  1'b0);
          4'd4: u = mk(1'b1, 7,  ACT_TMP,      1'b0);
          4'd5: u = mk(1'b1, 8,  ACT_MUL,      1'b0);
          4'd6: u = mk(1'b0, 0,  ACT_PROD_ADD, 1'b0);
          4'd7: u = mk(1'b0, 0,  ACT_WRITE,    1'b0);
          4'd8: u = mk(1'b0, 0,  ACT_DIFF,     1'b0);
          4'd9: u = mk(1'b0, 0,  ACT_NOISE,    1'b1);
          default: u = mk(1'b0, 0, ACT_NOISE, 1'b1);
        endcase
      end
      default: u = mk(1'b0, 0, ACT_WRITE, 1'b1);
    endcase
    return u;
  endfunction

endpackage

[hw/rtl/ltng_table.sv]
// 17-word mixing table: one read or write port, registered read, reset contents via valid bits.
module ltng_table (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ltng_pkg::tbl_req_t               req,
  output logic [ltng_pkg::WORD_W-1:0]      rd_data
);

  logic [ltng_pkg::WORD_W-1:0] mem [ltng_pkg::TBL_LEN];
  logic [ltng_pkg::TBL_LEN-1:0] vld_r;
  logic [ltng_pkg::WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= vld_r[req.addr] ? mem[req.addr] : ltng_pkg::RESET_WORDS[req.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/ltng_alu.sv]
// Shared arithmetic unit: one adder, one 16x16 multiplier, noise scaling multiplier.
module ltng_alu (
  input  ltng_pkg::act_t                   act,
  input  ltng_pkg::dp_t                    dp_i,
  input  logic [ltng_pkg::WORD_W-1:0]      rdata,
  input  logic [ltng_pkg::WORD_W-1:0]      seed,
  input  logic signed [ltng_pkg::AMP_W-1:0] amp,
  output ltng_pkg::dp_t                    dp_o
);

  logic [15:0]                 mul_a;
  logic [15:0]                 mul_b;
  logic [ltng_pkg::WORD_W-1:0] mul_p;
  logic [ltng_pkg::WORD_W-1:0] add_a;
  logic [ltng_pkg::WORD_W-1:0] add_b;
  logic [ltng_pkg::WORD_W-1:0] add_s;

  always_comb begin
    if (act == ltng_pkg::ACT_SEED_MUL) begin
      mul_a = dp_i.acc[31:16];
      mul_b = seed[15:0];
    end else begin
      mul_a = dp_i.tmp[15:0];
      mul_b = rdata[18:3];
    end
    mul_p = mul_a * mul_b;

    add_a = (act == ltng_pkg::ACT_SEED_ADD) ? rdata : dp_i.acc;
    case (act)
      ltng_pkg::ACT_XOR_ADD:  add_b = dp_i.tmp ^ rdata;
      ltng_pkg::ACT_ROT_ADD:  add_b = ltng_pkg::rotl3(rdata);
      ltng_pkg::ACT_PROD_ADD: add_b = dp_i.prod;
      ltng_pkg::ACT_SEED_ADD: add_b = dp_i.prod;
      default:                add_b = '0;
    endcase
    add_s = add_a + add_b;

    dp_o = dp_i;
    case (act)
      ltng_pkg::ACT_LOAD:     dp_o.acc = rdata;
      ltng_pkg::ACT_TMP:      dp_o.tmp = rdata;
      ltng_pkg::ACT_XOR_ADD:  dp_o.acc = add_s;
      ltng_pkg::ACT_ROT_ADD:  dp_o.acc = add_s;
      ltng_pkg::ACT_PROD_ADD: dp_o.acc = add_s;
      ltng_pkg::ACT_SEED_ADD: dp_o.acc = add_s;
      ltng_pkg::ACT_MUL:      dp_o.prod = mul_p;
      ltng_pkg::ACT_SEED_MUL: dp_o.prod = mul_p;
      ltng_pkg::ACT_SEED_XOR: dp_o.acc = rdata ^ {seed[7:0], seed[31:8]};
      ltng_pkg::ACT_DIFF:     dp_o.diff = ltng_pkg::DIFF_BIAS - $signed({1'b0, dp_i.acc});
      ltng_pkg::ACT_NOISE:    dp_o.nprod = $signed(amp) * $signed(dp_i.diff);
      ltng_pkg::ACT_WRITE:    dp_o = dp_i;
      default:                dp_o = dp_i;
    endcase
  end

endmodule

[hw/rtl/ltng_seq.sv]
// Sequencer: runs the seed, mix and per-request microprograms over the shared unit.
module ltng_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [ltng_pkg::AMP_W-1:0] amplitude,
  input  logic [ltng_pkg::WORD_W-1:0]       seed,
  output logic                              idle,
  output ltng_pkg::res_t                    res,
  input  logic                              take,
  output ltng_pkg::tbl_req_t                tbl,
  input  logic [ltng_pkg::WORD_W-1:0]       rd_data
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t                              st_r, st_nxt;
  ltng_pkg::prog_t                     prog_r, prog_nxt;
  logic [ltng_pkg::UPC_W-1:0]          upc_r, upc_nxt;
  logic [ltng_pkg::IDX_W-1:0]          base_r, base_nxt;
  logic [ltng_pkg::ROUND_W-1:0]        round_r, round_nxt;
  logic [ltng_pkg::IDX_W-1:0]          pos_r, pos_nxt;
  logic                                seeded_r, seeded_nxt;
  logic signed [ltng_pkg::AMP_W-1:0]   amp_r, amp_nxt;
  ltng_pkg::dp_t                       dp_r, dp_nxt, alu_out;
  ltng_pkg::uop_t                      u;
  logic [ltng_pkg::IDX_W-1:0]          next_pos;
  logic                                apply;
  logic                                adv;

  ltng_alu u_alu (
    .act   (u.act),
    .dp_i  (dp_r),
    .rdata (rd_data),
    .seed  (seed),
    .amp   (amp_r),
    .dp_o  (alu_out)
  );

  always_comb begin
    u        = ltng_pkg::uop(prog_r, upc_r);
    next_pos = (pos_r == ltng_pkg::IDX_W'(ltng_pkg::TBL_LEN - 1)) ? '0 :
               pos_r + ltng_pkg::IDX_W'(1);

    st_nxt     = st_r;
    prog_nxt   = prog_r;
    upc_nxt    = upc_r;
    base_nxt   = base_r;
    round_nxt  = round_r;
    pos_nxt    = pos_r;
    seeded_nxt = seeded_r;
    amp_nxt    = amp_r;
    dp_nxt     = dp_r;
    apply      = 1'b0;
    adv        = 1'b0;

    tbl.rd_en   = 1'b0;
    tbl.wr_en   = 1'b0;
    tbl.addr    = ltng_pkg::addr_wrap(base_r, u.off);
    tbl.wr_data = dp_r.acc;

    case (st_r)
      ST_IDLE: begin
        if (start) begin
          amp_nxt = amplitude;
          upc_nxt = '0;
          st_nxt  = ST_ISSUE;
          if (!seeded_r) begin
            seeded_nxt = 1'b1;
            prog_nxt   = ltng_pkg::PROG_SEED;
            base_nxt   = '0;
          end else begin
            prog_nxt = ltng_pkg::PROG_REQ;
            base_nxt = next_pos;
            pos_nxt  = next_pos;
          end
        end
      end
      ST_ISSUE: begin
        if (u.rd) begin
          tbl.rd_en = 1'b1;
          st_nxt    = ST_EXEC;
        end else begin
          apply     = 1'b1;
          adv       = 1'b1;
          tbl.wr_en = (u.act == ltng_pkg::ACT_WRITE);
        end
      end
      ST_EXEC: begin
        apply  = 1'b1;
        adv    = 1'b1;
        st_nxt = ST_ISSUE;
      end
      ST_DONE: begin
        if (take) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase

    if (apply) begin
      dp_nxt = alu_out;
    end

    if (adv) begin
      if (!u.last) begin
        upc_nxt = upc_r + ltng_pkg::UPC_W'(1);
      end else begin
        upc_nxt = '0;
        case (prog_r)
          ltng_pkg::PROG_SEED: begin
            if (ltng_pkg::MIX_ROUNDS == 0) begin
              prog_nxt = ltng_pkg::PROG_REQ;
              base_nxt = next_pos;
              pos_nxt  = next_pos;
            end else begin
              prog_nxt  = ltng_pkg::PROG_MIX;
              base_nxt  = '0;
              round_nxt = '0;
            end
          end
          ltng_pkg::PROG_MIX: begin
            if (base_r == ltng_pkg::IDX_W'(ltng_pkg::TBL_LEN - 1)) begin
              base_nxt = '0;
              if (round_r == ltng_pkg::LAST_ROUND) begin
                prog_nxt = ltng_pkg::PROG_REQ;
                base_nxt = next_pos;
                pos_nxt  = next_pos;
              end else begin
                round_nxt = round_r + ltng_pkg::ROUND_W'(1);
              end
            end else begin
              base_nxt = base_r + ltng_pkg::IDX_W'(1);
            end
          end
          ltng_pkg::PROG_REQ: st_nxt = ST_DONE;
          default: st_nxt = ST_DONE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      prog_r   <= ltng_pkg::PROG_SEED;
      upc_r    <= '0;
      base_r   <= '0;
      round_r  <= '0;
      pos_r    <= '0;
      seeded_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      prog_r   <= prog_nxt;
      upc_r    <= upc_nxt;
      base_r   <= base_nxt;
      round_r  <= round_nxt;
      pos_r    <= pos_nxt;
      seeded_r <= seeded_nxt;
    end
  end

  always_ff @(posedge clk) begin
    amp_r <= amp_nxt;
    dp_r  <= dp_nxt;
  end

  assign idle         = (st_r == ST_IDLE);
  assign res.valid    = (st_r == ST_DONE);
  assign res.noise    = dp_r.nprod[ltng_pkg::NOISE_W+ltng_pkg::FRAC_SHIFT-1:ltng_pkg::FRAC_SHIFT];
  assign res.raw_word = dp_r.acc;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < ltng_pkg::IDX_W'(ltng_pkg::TBL_LEN))
    else $error("table position out of range");

  a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
    base_r < ltng_pkg::IDX_W'(ltng_pkg::TBL_LEN))
    else $error("word index out of range");

  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(tbl.rd_en && tbl.wr_en))
    else $error("table read and write in the same cycle");

  a_done_req: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DONE) |-> (prog_r == ltng_pkg::PROG_REQ && seeded_r))
    else $error("result presented outside a seeded request");

endmodule

[hw/rtl/lagged_table_noise_generator_core.sv]
// Top level of the lagged-table noise generator: ports, seed register, result register.
//
// Usage:
//   cfg_valid/cfg_ready/cfg_seed write the seed register; cfg_ready is always high.
//   in_valid/in_ready/in_amplitude carry one request (signed Q8.16 amplitude).
//   out_valid/out_ready/out_noise/out_raw_word carry one result per request.
// Request flow:
//   A steady request reads the single-port table six times in the shared
//   unit, then adds, writes back and scales. in_ready is high only while the
//   sequencer is idle, so a new request is accepted only after the previous
//   result has been handed on to the output register.
//   The first request after reset also seeds and mixes the table: seeding of
//   two words, then 136 word updates over eight rounds.
// Reset:
//   The table returns to its fixed contents, the position to zero, the block
//   to the unseeded state and the seed register to zero.
// Stall:
//   A finished result waits in the output register; the next request is taken
//   meanwhile, and the sequencer holds its own result until the register frees.
module lagged_table_noise_generator_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [ltng_pkg::AMP_W-1:0]  in_amplitude,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [ltng_pkg::NOISE_W-1:0] out_noise,
  output logic [ltng_pkg::WORD_W-1:0]        out_raw_word,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ltng_pkg::WORD_W-1:0]        cfg_seed
);

  logic [ltng_pkg::WORD_W-1:0]         seed_r;
  logic                                out_valid_r;
  logic signed [ltng_pkg::NOISE_W-1:0] out_noise_r;
  logic [ltng_pkg::WORD_W-1:0]         out_raw_word_r;
  logic                                idle;
  logic                                take;
  ltng_pkg::res_t                      res;
  ltng_pkg::tbl_req_t                  tbl;
  logic [ltng_pkg::WORD_W-1:0]         rd_data;

  ltng_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (tbl),
    .rd_data (rd_data)
  );

  ltng_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid),
    .amplitude (in_amplitude),
    .seed      (seed_r),
    .idle      (idle),
    .res       (res),
    .take      (take),
    .tbl       (tbl),
    .rd_data   (rd_data)
  );

  assign take      = !out_valid_r || out_ready;
  assign in_ready  = idle;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_valid) begin
      seed_r <= cfg_seed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res.valid) begin
      out_noise_r    <= res.noise;
      out_raw_word_r <= res.raw_word;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_noise    = out_noise_r;
  assign out_raw_word = out_raw_word_r;

endmodule

[tb/lagged_table_noise_generator_core_tb.sv]
// Self-checking testbench for the lagged-table noise generator core.
`timescale 1ns / 100ps

module lagged_table_noise_generator_core_tb;

  localparam int TBL_DEPTH      = 17;
  localparam int QUIET_LIMIT    = 8000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RX_HOLD_CYCLES = 300;

  typedef struct {
    logic signed [ltng_pkg::NOISE_W-1:0] noise;
    logic [ltng_pkg::WORD_W-1:0]         raw_word;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [ltng_pkg::AMP_W-1:0] in_amplitude = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [ltng_pkg::NOISE_W-1:0] out_noise;
  logic [ltng_pkg::WORD_W-1:0] out_raw_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ltng_pkg::WORD_W-1:0] cfg_seed = '0;

  // predictor state
  logic [31:0] mix_words [TBL_DEPTH] = '{
    32'h3847a384, 32'h56af9029, 32'hc3852109, 32'h01835567,
    32'h58927374, 32'h77733935, 32'habcdef09, 32'h19258761,
    32'h58585716, 32'hd08f0ea0, 32'h44a5face, 32'hc0feeba6,
    32'h67860a38, 32'h45871265, 32'h9fbc0e38, 32'h35175722,
    32'h45787162
  };
  int          mix_pos = 0;
  logic        mix_seeded = 1'b0;
  logic [31:0] seed_shadow = '0;

  sample_t pending_samples[$];
  sample_t oldest;
  int      mismatches = 0;
  int      quiet_cycles = 0;
  int      holds_asked = 0;
  int      holds_done = 0;
  logic    tx_gaps_on = 1'b1;
  logic    rx_gaps_on = 1'b1;

  lagged_table_noise_generator_core i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_amplitude (in_amplitude),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_noise    (out_noise),
    .out_raw_word (out_raw_word),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_seed     (cfg_seed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [31:0] rot_left3(input logic [31:0] v);
    return {v[28:0], v[31:29]};
  endfunction

  function automatic void seed_and_mix_table();
    logic [31:0] s;
    s = seed_shadow;
    mix_words[0] = mix_words[0] ^ {s[7:0], s[31:8]};
    mix_words[1] = mix_words[1] + ({16'h0, mix_words[0][31:16]} * {16'h0, s[15:0]});
    for (int r = 0; r < ltng_pkg::MIX_ROUNDS; r++) begin
      for (int i = 0; i < TBL_DEPTH; i++) begin
        mix_words[i] = mix_words[i] + (mix_words[(i + 7) % TBL_DEPTH] ^
                       mix_words[(i + 5) % TBL_DEPTH]) +
                       rot_left3(mix_words[(i + 13) % TBL_DEPTH]);
      end
    end
  endfunction

  function automatic sample_t predict_noise_sample(input logic signed [23:0] amp);
    sample_t     s;
    logic [31:0] lag7, lag8, lag13, lag4, lag10, prod, x;
    longint      diff, scaled;
    int          p;
    if (!mix_seeded) begin
      mix_seeded = 1'b1;
      seed_and_mix_table();
    end
    mix_pos = (mix_pos + 1) % TBL_DEPTH;
    p = mix_pos;
    lag7  = mix_words[(p + 7) % TBL_DEPTH];
    lag8  = mix_words[(p + 8) % TBL_DEPTH];
    lag13 = mix_words[(p + 13) % TBL_DEPTH];
    lag4  = mix_words[(p + 4) % TBL_DEPTH];
    lag10 = mix_words[(p + 10) % TBL_DEPTH];
    prod  = {16'h0, lag7[15:0]} * {16'h0, lag8[18:3]};
    x = mix_words[p] + (lag4 ^ lag13) + rot_left3(lag10) + prod;
    mix_words[p] = x;
    diff   = 64'sh8000_0000 - longint'({32'h0, x});
    scaled = longint'(amp) * diff;
    s.noise    = 25'(scaled >>> 31);
    s.raw_word = x;
    return s;
  endfunction

  function automatic logic [23:0] pick_amplitude();
    case ($urandom_range(0, 9))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return 24'($urandom_range(0, 3));
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ERROR %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_request(input logic [23:0] amp);
    int gap;
    gap = (tx_gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_amplitude <= amp;
    do @(posedge clk); while (!in_ready);
    pending_samples.push_back(predict_noise_sample(amp));
  endtask

  task automatic write_seed(input logic [31:0] value);
    @(negedge clk);
    in_valid  <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_seed  <= value;
    do @(posedge clk); while (!cfg_ready);
    seed_shadow = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_first_request_seeding();
    logic [23:0] picks [12] = '{
      24'h7fffff, 24'h800000, 24'h000000, 24'h000001, 24'hffffff, 24'h010000,
      24'hff0000, 24'h555555, 24'haaaaaa, 24'h400000, 24'hc00000, 24'h000100
    };
    write_seed(32'h0);
    write_seed($urandom());
    foreach (picks[i]) send_request(picks[i]);
    // past the position wrap
    repeat (8) send_request(pick_amplitude());
    wait_drained();
  endtask

  task automatic test_seed_after_seeding();
    write_seed(32'hffffffff);
    repeat (4) send_request(pick_amplitude());
    wait_drained();
    write_seed(32'h0);
    repeat (4) send_request(pick_amplitude());
    wait_drained();
  endtask

  task automatic test_random_traffic();
    repeat (300) send_request(pick_amplitude());
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    tx_gaps_on = 1'b0;
    holds_asked++;
    repeat (8) send_request(pick_amplitude());
    tx_gaps_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_pause_until_drained();
    repeat (10) send_request(pick_amplitude());
    wait_drained();
    repeat (10) send_request(pick_amplitude());
    wait_drained();
  endtask

  task automatic test_full_rate();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    repeat (40) send_request(pick_amplitude());
    wait_drained();
  endtask

  // receiver: random stall bursts, plus a long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (holds_asked != holds_done) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end else if (rx_gaps_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("result with no request pending", out_raw_word, 32'h0);
      end else begin
        oldest = pending_samples.pop_front();
        if (out_noise !== oldest.noise)
          report_mismatch("noise", 32'(out_noise), 32'(oldest.noise));
        if (out_raw_word !== oldest.raw_word)
          report_mismatch("raw_word", out_raw_word, oldest.raw_word);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t ERROR watchdog: no progress", $time);
        $display("lagged_table_noise_generator_core_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_first_request_seeding();
    test_seed_after_seeding();
    test_random_traffic();
    test_output_backpressure();
    test_pause_until_drained();
    test_full_rate();
    if (pending_samples.size() != 0)
      report_mismatch("requests left without result", pending_samples.size(), 32'h0);
    if (mismatches == 0) begin
      $display("lagged_table_noise_generator_core_tb: PASS");
    end else begin
      $display("lagged_table_noise_generator_core_tb: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/ltng_pkg.sv
hw/rtl/ltng_table.sv
hw/rtl/ltng_alu.sv
hw/rtl/ltng_seq.sv
hw/rtl/lagged_table_noise_generator_core.sv
tb/lagged_table_noise_generator_core_tb.sv
